// ===== rtl/core/vpr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and tap tables of the vertical 3/2 polyphase resampler.
package vpr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int STORED_ROWS = 8;
  localparam int USED_ROWS   = 6;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int SLOT_W      = $clog2(STORED_ROWS);
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [10:0] ROW_WIDTH_RESET  = 11'd1024;
  localparam logic [12:0] FRAME_ROWS_RESET = 13'd480;
  localparam logic [12:0] FRAME_ROWS_MAX   = 13'd4096;
  localparam logic [12:0] ROW_COUNT_MAX    = 13'd8191;
  localparam logic [10:0] WIDTH_LIMIT      = 11'(MAX_WIDTH);

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ROW_WIDTH  = 2'd0;
  localparam reg_idx_t REG_FRAME_ROWS = 2'd1;

  typedef logic signed [15:0] sample_t;
  typedef sample_t [STORED_ROWS-1:0] line_word_t;

  // Taps for source rows one to six above the current row, by output phase.
  localparam sample_t TAP_PH0 [USED_ROWS] = '{16'sd0, 16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd0};
  localparam sample_t TAP_PH1 [USED_ROWS] = '{16'sd2, -16'sd7, 16'sd25, 16'sd51, -16'sd9, 16'sd2};
  localparam sample_t TAP_PH2 [USED_ROWS] = '{16'sd2, -16'sd9, 16'sd51, 16'sd25, -16'sd7, 16'sd2};

  typedef struct packed {
    sample_t                pixel;
    logic [COL_W-1:0]       col;
    logic [SLOT_W-1:0]      slot;
    logic                   odd;
    logic [USED_ROWS-1:0]   smask;
    logic                   va;
    logic                   vb;
    logic [12:0]            klo;
  } item_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    line_word_t       data;
  } mem_wr_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_stat_t;

  typedef struct packed {
    logic             two;
    sample_t          v0;
    logic [12:0]      k0;
    sample_t          v1;
    logic [12:0]      k1;
    logic [COL_W-1:0] col;
  } result_t;

endpackage

// ===== rtl/core/vpr_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces for the pixel, result and configuration channels.
interface vpr_pix_if;
  logic              valid;
  logic              ready;
  vpr_pkg::sample_t  pixel;
  logic              frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface vpr_res_if;
  logic              valid;
  logic              ready;
  vpr_pkg::sample_t  value;
  logic [12:0]       out_row;
  logic [9:0]        out_column;
  logic              last;
  modport source (output valid, output value, output out_row, output out_column,
                  output last, input ready);
  modport sink (input valid, input value, input out_row, input out_column,
                input last, output ready);
endinterface

interface vpr_cfg_if;
  logic               valid;
  logic               ready;
  vpr_pkg::reg_idx_t  index;
  logic [12:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/vpr_line_mem.sv =====
`timescale 1ns / 1ps
// Line store: one word per column holding that column of all stored rows.
module vpr_line_mem (
  input  logic                            clk,
  input  vpr_pkg::mem_wr_t                wr,
  input  logic [vpr_pkg::COL_W-1:0]       rd_addr,
  output vpr_pkg::line_word_t             rd_data
);

  vpr_pkg::line_word_t mem [vpr_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/vpr_ctrl.sv =====
`timescale 1ns / 1ps
// Configuration registers, row and column counters, clearing pass and input admission.
module vpr_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  vpr_cfg_if.sink                      cfg,
  vpr_pix_if.sink                      src,
  input  vpr_pkg::pipe_stat_t          pipe,
  input  logic [vpr_pkg::Q_CNT_W-1:0]  q_level,
  output logic                         item_valid,
  output vpr_pkg::item_t               item,
  output logic [vpr_pkg::COL_W-1:0]    rd_addr,
  output vpr_pkg::mem_wr_t             clr_wr
);

  logic [10:0]                 row_width;
  logic [12:0]                 frame_rows;
  logic [vpr_pkg::COL_W-1:0]   column_count;
  logic [12:0]                 row_count;
  logic                        clr_busy;
  logic [vpr_pkg::COL_W-1:0]   clr_addr;

  logic [10:0]                 w_eff;
  logic [12:0]                 rows_eff;
  logic [vpr_pkg::COL_W-1:0]   cbase;
  logic [12:0]                 rbase;
  logic [vpr_pkg::COL_W-1:0]   col;
  logic [10:0]                 col_inc;
  logic                        wrap;
  logic [14:0]                 x3;
  logic [14:0]                 h;
  logic signed [15:0]          klo;
  logic signed [15:0]          kb;
  logic [14:0]                 lim3;
  logic signed [15:0]          lim_s;
  logic [3:0]                  occ;
  logic [vpr_pkg::USED_ROWS-1:0] smask;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= vpr_pkg::ROW_WIDTH_RESET;
      frame_rows <= vpr_pkg::FRAME_ROWS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        vpr_pkg::REG_ROW_WIDTH:  row_width  <= cfg.data[10:0];
        vpr_pkg::REG_FRAME_ROWS: frame_rows <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == vpr_pkg::COL_W'(vpr_pkg::MAX_WIDTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  assign clr_wr.en   = clr_busy;
  assign clr_wr.addr = clr_addr;
  assign clr_wr.data = '0;

  assign occ        = 4'(q_level) + 4'(pipe.s1) + 4'(pipe.s2);
  assign src.ready  = !clr_busy && (occ < 4'(vpr_pkg::Q_DEPTH));
  assign item_valid = src.valid && src.ready;

  always_comb begin
    if (row_width == 11'd0) begin
      w_eff = 11'd1;
    end else if (row_width > vpr_pkg::WIDTH_LIMIT) begin
      w_eff = vpr_pkg::WIDTH_LIMIT;
    end else begin
      w_eff = row_width;
    end
    rows_eff = (frame_rows > vpr_pkg::FRAME_ROWS_MAX) ? vpr_pkg::FRAME_ROWS_MAX : frame_rows;

    cbase   = src.frame_start ? '0 : column_count;
    rbase   = src.frame_start ? '0 : row_count;
    col     = (11'(cbase) >= w_eff) ? '0 : cbase;
    col_inc = 11'(col) + 11'd1;
    wrap    = col_inc >= w_eff;

    x3    = 15'({rbase, 1'b0}) + 15'(rbase);
    h     = x3 + 15'(rbase[0]);
    klo   = $signed({2'b00, h[14:1]}) - 16'sd6;
    kb    = klo + 16'sd1;
    lim3  = 15'({rows_eff, 1'b0}) + 15'(rows_eff) + 15'd1;
    lim_s = $signed({2'b00, lim3[14:1]});

    for (int i = 0; i < vpr_pkg::USED_ROWS; i++) begin
      smask[i] = (rbase >= 13'(i + 1)) && (14'(rbase) < 14'(rows_eff) + 14'(i + 1));
    end

    item.pixel = src.pixel;
    item.col   = col;
    item.slot  = rbase[vpr_pkg::SLOT_W-1:0];
    item.odd   = rbase[0];
    item.smask = smask;
    item.va    = !klo[15] && (klo < lim_s);
    item.vb    = !rbase[0] && !kb[15] && (kb < lim_s);
    item.klo   = klo[12:0];
  end

  assign rd_addr = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (item_valid) begin
      if (wrap) begin
        column_count <= '0;
        row_count    <= (rbase < vpr_pkg::ROW_COUNT_MAX) ? rbase + 13'd1 : rbase;
      end else begin
        column_count <= col_inc[vpr_pkg::COL_W-1:0];
        row_count    <= rbase;
      end
    end
  end

endmodule

// ===== rtl/core/vpr_filter.sv =====
`timescale 1ns / 1ps
// Read-modify-write of the column word with forwarding, tap products and phase sums.
module vpr_filter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  vpr_pkg::item_t        item,
  input  vpr_pkg::line_word_t   rd_data,
  output vpr_pkg::mem_wr_t      mem_wr,
  output vpr_pkg::pipe_stat_t   pipe,
  output logic                  push,
  output vpr_pkg::result_t      entry
);

  logic                        v1;
  vpr_pkg::item_t              it1;
  logic                        fwd_valid;
  logic [vpr_pkg::COL_W-1:0]   fwd_addr;
  vpr_pkg::line_word_t         fwd_data;
  logic                        v2;
  vpr_pkg::item_t              it2;
  vpr_pkg::sample_t            pa_q [vpr_pkg::USED_ROWS];
  vpr_pkg::sample_t            pb_q [vpr_pkg::USED_ROWS];

  vpr_pkg::line_word_t         word;
  vpr_pkg::line_word_t         new_word;
  vpr_pkg::sample_t            samp [vpr_pkg::USED_ROWS];
  vpr_pkg::sample_t            pa [vpr_pkg::USED_ROWS];
  vpr_pkg::sample_t            pb [vpr_pkg::USED_ROWS];
  vpr_pkg::sample_t            sa;
  vpr_pkg::sample_t            sb;

  // The word written last cycle is not yet visible in the read data of the same column.
  always_comb begin
    word = (fwd_valid && (fwd_addr == it1.col)) ? fwd_data : rd_data;
    new_word = word;
    new_word[it1.slot] = it1.pixel;
    for (int i = 0; i < vpr_pkg::USED_ROWS; i++) begin
      samp[i] = it1.smask[i] ? word[it1.slot - vpr_pkg::SLOT_W'(i + 1)] : '0;
      pa[i]   = it1.odd ? samp[i] * vpr_pkg::TAP_PH1[i] : samp[i] * vpr_pkg::TAP_PH0[i];
      pb[i]   = samp[i] * vpr_pkg::TAP_PH2[i];
    end
  end

  assign mem_wr.en   = v1;
  assign mem_wr.addr = it1.col;
  assign mem_wr.data = new_word;
  assign pipe.s1     = v1;
  assign pipe.s2     = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      v1        <= item_valid;
      v2        <= v1;
      fwd_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    it1      <= item;
    fwd_addr <= it1.col;
    fwd_data <= new_word;
    it2      <= it1;
    pa_q     <= pa;
    pb_q     <= pb;
  end

  always_comb begin
    sa = '0;
    sb = '0;
    for (int i = 0; i < vpr_pkg::USED_ROWS; i++) begin
      sa = sa + pa_q[i];
      sb = sb + pb_q[i];
    end
    push      = v2 && (it2.va || it2.vb);
    entry.two = it2.va && it2.vb;
    entry.v0  = it2.va ? sa : sb;
    entry.k0  = it2.va ? it2.klo : it2.klo + 13'd1;
    entry.v1  = sb;
    entry.k1  = it2.klo + 13'd1;
    entry.col = it2.col;
  end

endmodule

// ===== rtl/core/vpr_out_queue.sv =====
`timescale 1ns / 1ps
// Result queue that holds one entry per pixel that gives a result and hands out its one or two words.
module vpr_out_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  vpr_pkg::result_t             entry,
  output logic [vpr_pkg::Q_CNT_W-1:0]  level,
  vpr_res_if.source                    dst
);

  vpr_pkg::result_t              q [vpr_pkg::Q_DEPTH];
  logic [vpr_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [vpr_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [vpr_pkg::Q_CNT_W-1:0]   count;
  logic                          phase;

  vpr_pkg::result_t              head;
  logic                          is_last;
  logic                          take;
  logic                          pop;

  assign head           = q[rd_ptr];
  assign is_last        = !head.two || phase;
  assign dst.valid      = (count != '0);
  assign dst.value      = phase ? head.v1 : head.v0;
  assign dst.out_row    = phase ? head.k1 : head.k0;
  assign dst.out_column = 10'(head.col);
  assign dst.last       = is_last;
  assign take           = dst.valid && dst.ready;
  assign pop            = take && is_last;
  assign level          = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      phase  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
      if (take) begin
        phase <= !is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

endmodule

// ===== rtl/core/vertical_polyphase_resample_3_2_unit.sv =====
`timescale 1ns / 1ps
// Top level of the vertical 3/2 polyphase resampler.
//
// Pixels arrive on src in raster order with frame_start on the first pixel of a
// frame; results leave on dst, one word per output sample, with last set on the
// final word caused by a pixel. Even source rows give up to two words, odd rows
// at most one. The cfg channel writes row_width and frame_rows and is always ready.
// A pixel is accepted when src is valid and ready; its first word passes the it1
// register, the it2 and product registers and the result queue before it is
// valid on dst. A pixel enters every cycle while the result queue has room, so
// the sustained rate is set by the result channel and is lower on rows that
// give two words per pixel. Each pixel makes one read and one write of
// its column word in the line store, so the single store port pair sets no
// further limit.
// After reset the line store is cleared, one column a cycle, over all 1024 columns,
// and src is not ready during that pass. When dst stalls, words wait in a four-entry
// queue and src goes not ready once queued entries and pipeline pixels number four.
module vertical_polyphase_resample_3_2_unit (
  input  logic       clk,
  input  logic       rst,
  vpr_cfg_if.sink    cfg,
  vpr_pix_if.sink    src,
  vpr_res_if.source  dst
);

  logic                            item_valid;
  vpr_pkg::item_t                  item;
  logic [vpr_pkg::COL_W-1:0]       rd_addr;
  vpr_pkg::line_word_t             rd_data;
  vpr_pkg::mem_wr_t                clr_wr;
  vpr_pkg::mem_wr_t                flt_wr;
  vpr_pkg::mem_wr_t                mem_wr;
  vpr_pkg::pipe_stat_t             pipe;
  logic                            push;
  vpr_pkg::result_t                entry;
  logic [vpr_pkg::Q_CNT_W-1:0]     q_level;

  assign mem_wr = clr_wr.en ? clr_wr : flt_wr;

  vpr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .src        (src),
    .pipe       (pipe),
    .q_level    (q_level),
    .item_valid (item_valid),
    .item       (item),
    .rd_addr    (rd_addr),
    .clr_wr     (clr_wr)
  );

  vpr_line_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  vpr_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .rd_data    (rd_data),
    .mem_wr     (flt_wr),
    .pipe       (pipe),
    .push       (push),
    .entry      (entry)
  );

  vpr_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .level (q_level),
    .dst   (dst)
  );

endmodule
